### rtl/assert_macros.svh
// Assertion macros for the RTL files; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds after ante, delayed by dly.
`define ASSERT_DELAYED(lbl, clk, rst, ante, dly, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_DELAYED(lbl, clk, rst, ante, dly, cons, msg)

`endif

`endif

### rtl/hsv2rgb_pkg.sv
// Constants and types for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

   // Input field widths and valid limits
   localparam int HUE_W       = 15;
   localparam int PCT_W       = 13;
   localparam int HUE_MAX     = 23040;   // 360 degrees in 1/64 degree
   localparam int PCT_MAX     = 6400;    // 100 percent in 1/64 percent
   localparam int SECTOR_SPAN = 3840;    // 60 degrees in 1/64 degree

   // Distance from the nearest sector-pair edge is at most one sector span
   localparam int T_W     = 12;
   // Per-channel multiplicand before the brightness multiply
   localparam int INNER_W = 25;

   // Common denominator 6400*6400*3840 = 2^24 * 9375
   localparam int DEN_POW2 = 24;
   localparam int DEN_ODD  = 9375;

   // Reciprocal of DEN_ODD for the constant divide
   localparam int RECIP_SHIFT = 44;
   localparam int RECIP_W     = 31;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / DEN_ODD);

   localparam int OUT_FRAC_BITS_DEF = 12;

   // 60-degree hue sectors, named by the colors they span
   typedef enum logic [2:0] {
      SECT_RY,   // red to yellow
      SECT_YG,   // yellow to green
      SECT_GC,   // green to cyan
      SECT_CB,   // cyan to blue
      SECT_BM,   // blue to magenta
      SECT_MR    // magenta to red, including 360 degrees
   } sector_type;

endpackage

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// Top level: pipelined HSV to RGB pixel converter.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   request | in        | start / busy           | req_hue, req_saturation, req_brightness
//   result  | out       | rsp_strobe (one cycle) | rsp_red, rsp_green, rsp_blue, rsp_in_range
//
// One pixel enters per clock; busy stays low.
// Each result passes through the seven-stage multiply chain (sector/offset,
// chroma terms, select, brightness multiply, reciprocal multiply, remainder,
// correction) before it reaches the result ports.
// Synchronous reset clears the stage valid bits only; no results follow it
// until new transfers arrive. The receiver cannot stall, so nothing holds.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hsv_to_rgb_converter #(
   parameter int OUT_FRAC_BITS = hsv2rgb_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [hsv2rgb_pkg::HUE_W-1:0]  req_hue,
   input  logic [hsv2rgb_pkg::PCT_W-1:0]  req_saturation,
   input  logic [hsv2rgb_pkg::PCT_W-1:0]  req_brightness,
   output logic                           rsp_strobe,
   output logic [OUT_FRAC_BITS:0]         rsp_red,
   output logic [OUT_FRAC_BITS:0]         rsp_green,
   output logic [OUT_FRAC_BITS:0]         rsp_blue,
   output logic                           rsp_in_range
);

   localparam int LATENCY   = 7;
   localparam int OUT_W     = OUT_FRAC_BITS + 1;
   localparam int HUE_W     = hsv2rgb_pkg::HUE_W;
   localparam int PCT_W     = hsv2rgb_pkg::PCT_W;
   localparam int T_W       = hsv2rgb_pkg::T_W;
   localparam int INNER_W   = hsv2rgb_pkg::INNER_W;
   localparam int SHIFT     = hsv2rgb_pkg::DEN_POW2 - OUT_FRAC_BITS;
   localparam int NUM_W     = PCT_W + INNER_W;
   localparam int QD_W      = NUM_W - SHIFT;
   localparam int PROD_W    = QD_W + hsv2rgb_pkg::RECIP_W;
   localparam int Q_W       = PROD_W - hsv2rgb_pkg::RECIP_SHIFT;
   localparam int DEN_ODD_W = $clog2(hsv2rgb_pkg::DEN_ODD);
   localparam int REM_W     = DEN_ODD_W + 1;
   localparam int SPAN      = hsv2rgb_pkg::SECTOR_SPAN;
   localparam logic [INNER_W-1:0] HI_INNER =
      INNER_W'(hsv2rgb_pkg::PCT_MAX * hsv2rgb_pkg::SECTOR_SPAN);

   logic accept;
   logic [LATENCY-1:0] vld_ff, vld_in;

   // Stage 1: range check, sector, distance from the sector-pair edge
   logic                       ok_in;
   hsv2rgb_pkg::sector_type    sect_in;
   logic [HUE_W-1:0]           base_in, pos_in, t_full_in;
   logic                       s1_ok_ff;
   hsv2rgb_pkg::sector_type    s1_sect_ff;
   logic [PCT_W-1:0]           s1_sat_ff, s1_bri_ff;
   logic [T_W-1:0]             s1_t_ff;

   // Stage 2: chroma terms
   logic [PCT_W-1:0]           cs_in;
   logic                       s2_ok_ff;
   hsv2rgb_pkg::sector_type    s2_sect_ff;
   logic [PCT_W-1:0]           s2_bri_ff;
   logic [INNER_W-1:0]         s2_st_ff, s2_lo_ff;

   // Stage 3: component order
   logic [INNER_W-1:0]         mid_in;
   logic [INNER_W-1:0]         inner_in [3];
   logic                       s3_ok_ff;
   logic [PCT_W-1:0]           s3_bri_ff;
   logic [INNER_W-1:0]         s3_inner_ff [3];

   // Stages 4 to 7: per-channel numerator and divide by the denominator
   logic                       s4_ok_ff, s5_ok_ff, s6_ok_ff;
   logic [NUM_W-1:0]           s4_num_ff [3];
   logic [QD_W-1:0]            qd_in [3];
   logic [QD_W-1:0]            s5_qd_ff [3];
   logic [PROD_W-1:0]          s5_prod_ff [3];
   logic [Q_W-1:0]             qe_in [3];
   logic [QD_W-1:0]            rem_full_in [3];
   logic [Q_W-1:0]             s6_q_ff [3];
   logic [REM_W-1:0]           s6_rem_ff [3];
   logic [Q_W-1:0]             q_in [3];
   logic [OUT_W-1:0]           s7_rgb_ff [3];
   logic                       s7_ok_ff;

   // Never hold off a transfer
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Advance the valid bits
   assign vld_in = {vld_ff[LATENCY-2:0], accept};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Find the sector and the distance from the nearest sector-pair edge
   always_comb begin
      ok_in = (req_hue <= HUE_W'(hsv2rgb_pkg::HUE_MAX))
           && (req_saturation <= PCT_W'(hsv2rgb_pkg::PCT_MAX))
           && (req_brightness <= PCT_W'(hsv2rgb_pkg::PCT_MAX));
      if (req_hue < HUE_W'(SPAN)) begin
         sect_in = hsv2rgb_pkg::SECT_RY;
      end else if (req_hue < HUE_W'(2 * SPAN)) begin
         sect_in = hsv2rgb_pkg::SECT_YG;
      end else if (req_hue < HUE_W'(3 * SPAN)) begin
         sect_in = hsv2rgb_pkg::SECT_GC;
      end else if (req_hue < HUE_W'(4 * SPAN)) begin
         sect_in = hsv2rgb_pkg::SECT_CB;
      end else if (req_hue < HUE_W'(5 * SPAN)) begin
         sect_in = hsv2rgb_pkg::SECT_BM;
      end else begin
         sect_in = hsv2rgb_pkg::SECT_MR;
      end
      if (req_hue < HUE_W'(2 * SPAN)) begin
         base_in = '0;
      end else if (req_hue < HUE_W'(4 * SPAN)) begin
         base_in = HUE_W'(2 * SPAN);
      end else begin
         base_in = HUE_W'(4 * SPAN);
      end
      pos_in    = req_hue - base_in;
      t_full_in = (pos_in >= HUE_W'(SPAN)) ? (HUE_W'(2 * SPAN) - pos_in) : pos_in;
   end

   // Form the chroma terms s*t and (6400-s)*3840
   assign cs_in = PCT_W'(hsv2rgb_pkg::PCT_MAX) - s1_sat_ff;

   // Order the components by sector
   always_comb begin
      mid_in = s2_st_ff + s2_lo_ff;
      case (s2_sect_ff)
         hsv2rgb_pkg::SECT_RY: begin
            inner_in[0] = HI_INNER; inner_in[1] = mid_in;   inner_in[2] = s2_lo_ff;
         end
         hsv2rgb_pkg::SECT_YG: begin
            inner_in[0] = mid_in;   inner_in[1] = HI_INNER; inner_in[2] = s2_lo_ff;
         end
         hsv2rgb_pkg::SECT_GC: begin
            inner_in[0] = s2_lo_ff; inner_in[1] = HI_INNER; inner_in[2] = mid_in;
         end
         hsv2rgb_pkg::SECT_CB: begin
            inner_in[0] = s2_lo_ff; inner_in[1] = mid_in;   inner_in[2] = HI_INNER;
         end
         hsv2rgb_pkg::SECT_BM: begin
            inner_in[0] = mid_in;   inner_in[1] = s2_lo_ff; inner_in[2] = HI_INNER;
         end
         default: begin
            inner_in[0] = HI_INNER; inner_in[1] = s2_lo_ff; inner_in[2] = mid_in;
         end
      endcase
   end

   // Divide by 2^SHIFT * 9375: shift, reciprocal estimate, one correction
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qd_in[c]       = s4_num_ff[c][NUM_W-1:SHIFT];
         qe_in[c]       = s5_prod_ff[c][PROD_W-1:hsv2rgb_pkg::RECIP_SHIFT];
         rem_full_in[c] = s5_qd_ff[c]
                        - QD_W'(QD_W'(qe_in[c]) * QD_W'(hsv2rgb_pkg::DEN_ODD));
         q_in[c]        = (s6_rem_ff[c] >= REM_W'(hsv2rgb_pkg::DEN_ODD))
                        ? (s6_q_ff[c] + Q_W'(1)) : s6_q_ff[c];
      end
   end

   // Advance the payload through the stages
   always_ff @(posedge clock) begin
      s1_ok_ff   <= ok_in;
      s1_sect_ff <= sect_in;
      s1_sat_ff  <= req_saturation;
      s1_bri_ff  <= req_brightness;
      s1_t_ff    <= t_full_in[T_W-1:0];

      s2_ok_ff   <= s1_ok_ff;
      s2_sect_ff <= s1_sect_ff;
      s2_bri_ff  <= s1_bri_ff;
      s2_st_ff   <= INNER_W'(s1_sat_ff) * INNER_W'(s1_t_ff);
      s2_lo_ff   <= INNER_W'(cs_in) * INNER_W'(SPAN);

      s3_ok_ff   <= s2_ok_ff;
      s3_bri_ff  <= s2_bri_ff;
      s4_ok_ff   <= s3_ok_ff;
      s5_ok_ff   <= s4_ok_ff;
      s6_ok_ff   <= s5_ok_ff;
      s7_ok_ff   <= s6_ok_ff;

      for (int c = 0; c < 3; c++) begin
         s3_inner_ff[c] <= inner_in[c];
         s4_num_ff[c]   <= NUM_W'(s3_bri_ff) * NUM_W'(s3_inner_ff[c]);
         s5_qd_ff[c]    <= qd_in[c];
         s5_prod_ff[c]  <= PROD_W'(qd_in[c]) * PROD_W'(hsv2rgb_pkg::RECIP);
         s6_q_ff[c]     <= qe_in[c];
         s6_rem_ff[c]   <= rem_full_in[c][REM_W-1:0];
         s7_rgb_ff[c]   <= s6_ok_ff ? OUT_W'(q_in[c]) : '0;
      end
   end

   // Drive the result ports
   assign rsp_strobe   = vld_ff[LATENCY-1];
   assign rsp_red      = s7_rgb_ff[0];
   assign rsp_green    = s7_rgb_ff[1];
   assign rsp_blue     = s7_rgb_ff[2];
   assign rsp_in_range = s7_ok_ff;

   // Checks on latency, range handling and output bounds
   `ASSERT_DELAYED(a_latency, clock, reset, accept, 7, rsp_strobe, "result missing after transfer")
   `ASSERT_IMPLIES(a_no_phantom, clock, reset, rsp_strobe, $past(accept, 7), "result without transfer")
   `ASSERT_DELAYED(a_bad_hue, clock, reset, accept && (req_hue > HUE_W'(hsv2rgb_pkg::HUE_MAX)), 7, !rsp_in_range, "bad hue reported in range")
   `ASSERT_IMPLIES(a_zero_out, clock, reset, rsp_strobe && !rsp_in_range, (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0), "out-of-range result not zero")
   `ASSERT_IMPLIES(a_bound, clock, reset, rsp_strobe && rsp_in_range, (rsp_red <= OUT_W'(1 << OUT_FRAC_BITS)) && (rsp_green <= OUT_W'(1 << OUT_FRAC_BITS)) && (rsp_blue <= OUT_W'(1 << OUT_FRAC_BITS)), "component above full scale")

endmodule

`default_nettype wire
